FILE: rtl/core/chs_pkg.sv
// Package for the compass heading smoother.
// Holds the request types, fixed-point widths, the arctangent table and the sequencer states.
// No dependencies.
package chs_pkg;

  localparam int ANGLE_FRACTION_BITS = 6;
  localparam int CORDIC_ITERATIONS   = 16;

  localparam int ATAN_LEN  = 24;
  localparam int ITER_CNT  = (CORDIC_ITERATIONS > ATAN_LEN) ? ATAN_LEN : CORDIC_ITERATIONS;
  localparam int ITER_W    = (ITER_CNT > 1) ? $clog2(ITER_CNT) : 1;
  localparam int TAB_IDX_W = $clog2(ATAN_LEN);

  localparam int ACC_FRAC      = 16;
  localparam int INPUT_GAIN_SH = 8;
  localparam int SAMPLE_W      = 16;
  localparam int XY_W          = 28;
  localparam int Z_W           = 27;
  localparam int ATAN_W        = 22;

  localparam int FULL_ACC_I = 360 << ACC_FRAC;
  localparam int HALF_ACC_I = 180 << ACC_FRAC;
  localparam int RND_SH     = ACC_FRAC - ANGLE_FRACTION_BITS;
  localparam int RND_HALF_I = 1 << (RND_SH - 1);

  localparam int FULL_TURN_I     = 360 << ANGLE_FRACTION_BITS;
  localparam int HALF_TURN_I     = 180 << ANGLE_FRACTION_BITS;
  localparam int SECTOR_OFFSET_I = 45 << (ANGLE_FRACTION_BITS - 1);
  localparam int HD_W            = $clog2(FULL_TURN_I);
  localparam int DIFF_W          = HD_W + 1;
  localparam int SUM_W           = HD_W + 2;

  localparam int FACTOR_W   = 16;
  localparam int PROD_W     = DIFF_W + FACTOR_W + 1;
  localparam int STEP_RND_I = 1 << (FACTOR_W - 1);

  localparam int HEADING_W = 15;
  localparam int SECTOR_W  = 3;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = 16'd9830;

  localparam logic [ATAN_W-1:0] ATAN_TABLE [ATAN_LEN] = '{
    22'd2949120, 22'd1740967, 22'd919879, 22'd466945, 22'd234379, 22'd117304,
    22'd58666,   22'd29335,   22'd14668,  22'd7334,   22'd3667,   22'd1833,
    22'd917,     22'd458,     22'd229,    22'd115,    22'd57,     22'd29,
    22'd14,      22'd7,       22'd4,      22'd2,      22'd1,      22'd0
  };

  typedef struct packed {
    logic signed [SAMPLE_W-1:0] field_x;
    logic signed [SAMPLE_W-1:0] field_y;
  } chs_in_t;

  typedef struct packed {
    logic [HEADING_W-1:0] raw_heading;
    logic [HEADING_W-1:0] smooth_heading;
    logic [SECTOR_W-1:0]  sector;
  } chs_out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROTATE,
    ST_ROUND,
    ST_DIFF,
    ST_MULT,
    ST_SUM,
    ST_EMIT
  } chs_state_e;

  typedef struct packed {
    logic load;
    logic step;
  } cordic_ctrl_t;

  typedef struct packed {
    logic round_en;
    logic diff_en;
    logic mult_en;
    logic sum_en;
  } blend_ctrl_t;

endpackage

FILE: rtl/core/chs_cordic.sv
// Iterative vectoring CORDIC: one shift/add/subtract step per cycle on x, y and angle.
// Depends on chs_pkg.
module chs_cordic (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  chs_pkg::cordic_ctrl_t        ctrl_i,
  input  chs_pkg::chs_in_t             sample_i,
  output logic signed [chs_pkg::Z_W-1:0] z_o,
  output logic                         zero_o,
  output logic                         last_o
);
  import chs_pkg::*;

  logic signed [XY_W-1:0]  x_q, x_d, y_q, y_d;
  logic signed [XY_W-1:0]  xs, ys, x_in, y_in;
  logic signed [Z_W-1:0]   z_q, z_d, atan_z;
  logic [ITER_W-1:0]       cnt_q, cnt_d;
  logic                    zero_q, zero_d;

  always_comb begin
    x_in   = {{(XY_W-SAMPLE_W){sample_i.field_x[SAMPLE_W-1]}}, sample_i.field_x} <<< INPUT_GAIN_SH;
    y_in   = {{(XY_W-SAMPLE_W){sample_i.field_y[SAMPLE_W-1]}}, sample_i.field_y} <<< INPUT_GAIN_SH;
    xs     = x_q >>> cnt_q;
    ys     = y_q >>> cnt_q;
    atan_z = $signed({{(Z_W-ATAN_W){1'b0}}, ATAN_TABLE[TAB_IDX_W'(cnt_q)]});
    x_d    = x_q;
    y_d    = y_q;
    z_d    = z_q;
    cnt_d  = cnt_q;
    zero_d = zero_q;
    if (ctrl_i.load) begin
      cnt_d  = '0;
      zero_d = (sample_i.field_x == '0) && (sample_i.field_y == '0);
      if (x_in < 0) begin
        x_d = -x_in;
        y_d = -y_in;
        z_d = Z_W'(HALF_ACC_I);
      end else begin
        x_d = x_in;
        y_d = y_in;
        z_d = '0;
      end
    end else if (ctrl_i.step) begin
      cnt_d = cnt_q + 1'b1;
      if (y_q >= 0) begin
        x_d = x_q + ys;
        y_d = y_q - xs;
        z_d = z_q + atan_z;
      end else begin
        x_d = x_q - ys;
        y_d = y_q + xs;
        z_d = z_q - atan_z;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      zero_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      zero_q <= zero_d;
    end
  end

  always_ff @(posedge clk_i) begin
    x_q <= x_d;
    y_q <= y_d;
    z_q <= z_d;
  end

  assign z_o    = z_q;
  assign zero_o = zero_q;
  assign last_o = (cnt_q == ITER_W'(ITER_CNT - 1));

endmodule

FILE: rtl/core/chs_blend.sv
// Heading rounding and wrap-aware exponential smoothing, one stage per sequencer step.
// Keeps the smoothed heading. Depends on chs_pkg.
module chs_blend (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  chs_pkg::blend_ctrl_t            ctrl_i,
  input  logic signed [chs_pkg::Z_W-1:0]  z_i,
  input  logic                            zero_i,
  input  logic [chs_pkg::FACTOR_W-1:0]    factor_i,
  output logic [chs_pkg::HD_W-1:0]        raw_o,
  output logic [chs_pkg::HD_W-1:0]        smooth_o
);
  import chs_pkg::*;

  logic signed [Z_W-1:0]    zn, zr;
  logic [HD_W-1:0]          raw_q, raw_d;
  logic signed [DIFF_W-1:0] diff_q, diff_d;
  logic signed [PROD_W-1:0] prod, diff_ext, factor_ext, prod_rnd;
  logic signed [DIFF_W-1:0] step_q, step_d;
  logic signed [SUM_W-1:0]  sum;
  logic [HD_W-1:0]          last_q, last_d;

  always_comb begin
    zn = z_i;
    if (zn < 0) begin
      zn = zn + Z_W'(FULL_ACC_I);
    end
    if (zn >= Z_W'(FULL_ACC_I)) begin
      zn = zn - Z_W'(FULL_ACC_I);
    end
    zr = (zn + Z_W'(RND_HALF_I)) >>> RND_SH;
    if (zr >= Z_W'(FULL_TURN_I)) begin
      zr = zr - Z_W'(FULL_TURN_I);
    end
    raw_d = zero_i ? '0 : HD_W'(zr);

    diff_d = $signed({1'b0, raw_q}) - $signed({1'b0, last_q});
    if (diff_d > DIFF_W'(HALF_TURN_I)) begin
      diff_d = diff_d - DIFF_W'(FULL_TURN_I);
    end else if (diff_d < -DIFF_W'(HALF_TURN_I)) begin
      diff_d = diff_d + DIFF_W'(FULL_TURN_I);
    end

    diff_ext   = {{(PROD_W-DIFF_W){diff_q[DIFF_W-1]}}, diff_q};
    factor_ext = $signed({{(PROD_W-FACTOR_W){1'b0}}, factor_i});
    prod       = diff_ext * factor_ext;
    prod_rnd   = (prod + PROD_W'(STEP_RND_I)) >>> FACTOR_W;
    step_d     = DIFF_W'(prod_rnd);

    sum = $signed({2'b00, last_q}) + {step_q[DIFF_W-1], step_q};
    if (sum < 0) begin
      sum = sum + SUM_W'(FULL_TURN_I);
    end else if (sum >= SUM_W'(FULL_TURN_I)) begin
      sum = sum - SUM_W'(FULL_TURN_I);
    end
    last_d = HD_W'(sum);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_q <= '0;
    end else if (ctrl_i.sum_en) begin
      last_q <= last_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.round_en) begin
      raw_q <= raw_d;
    end
    if (ctrl_i.diff_en) begin
      diff_q <= diff_d;
    end
    if (ctrl_i.mult_en) begin
      step_q <= step_d;
    end
  end

  assign raw_o    = raw_q;
  assign smooth_o = last_q;

endmodule

FILE: rtl/core/compass_heading_smoother.sv
// Top level of the compass heading smoother: sequencer, smoothing factor register, result register.
// Instantiates chs_cordic and chs_blend. Depends on chs_pkg.
//
// One X/Y sample request yields one result request: one load step, 16 passes through the
// shared CORDIC shift/add stage, then round, fold, multiply, sum and emit steps; emit waits
// while a stalled result still sits in the result register. A new sample is taken only once
// the sequencer is back in idle. The result register holds a finished result while the
// next sample is already being worked on. The smoothing factor may be written whenever the
// block is idle and takes effect on the next sample.
module compass_heading_smoother (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [chs_pkg::FACTOR_W-1:0]  cfg_wdata_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  chs_pkg::chs_in_t              in_req_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output chs_pkg::chs_out_t             out_req_o
);
  import chs_pkg::*;

  chs_state_e             state_q, state_d;
  cordic_ctrl_t           cordic_ctrl;
  blend_ctrl_t            blend_ctrl;
  logic signed [Z_W-1:0]  cordic_z;
  logic                   cordic_zero, cordic_last;
  logic [HD_W-1:0]        raw_heading, smooth_heading;
  logic [FACTOR_W-1:0]    factor_q;
  logic                   out_valid_q, out_load;
  chs_out_t               out_req_q;
  logic [SECTOR_W-1:0]    sector;

  chs_cordic u_cordic (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (cordic_ctrl),
    .sample_i (in_req_i),
    .z_o      (cordic_z),
    .zero_o   (cordic_zero),
    .last_o   (cordic_last)
  );

  chs_blend u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (blend_ctrl),
    .z_i      (cordic_z),
    .zero_i   (cordic_zero),
    .factor_i (factor_q),
    .raw_o    (raw_heading),
    .smooth_o (smooth_heading)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cordic_ctrl = '0;
    blend_ctrl  = '0;
    out_load    = 1'b0;
    in_stall_o  = (state_q != ST_IDLE);
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cordic_ctrl.load = 1'b1;
          state_d          = ST_ROTATE;
        end
      end
      ST_ROTATE: begin
        cordic_ctrl.step = 1'b1;
        if (cordic_last) begin
          state_d = ST_ROUND;
        end
      end
      ST_ROUND: begin
        blend_ctrl.round_en = 1'b1;
        state_d             = ST_DIFF;
      end
      ST_DIFF: begin
        blend_ctrl.diff_en = 1'b1;
        state_d            = ST_MULT;
      end
      ST_MULT: begin
        blend_ctrl.mult_en = 1'b1;
        state_d            = ST_SUM;
      end
      ST_SUM: begin
        blend_ctrl.sum_en = 1'b1;
        state_d           = ST_EMIT;
      end
      ST_EMIT: begin
        if (!out_valid_q || !out_stall_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_comb begin
    sector = '0;
    for (int k = 1; k < 8; k++) begin
      if (int'(smooth_heading) >= (2 * k - 1) * SECTOR_OFFSET_I) begin
        sector = SECTOR_W'(k);
      end
    end
    if (int'(smooth_heading) >= 15 * SECTOR_OFFSET_I) begin
      sector = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      factor_q <= FACTOR_RESET;
    end else if (cfg_we_i) begin
      factor_q <= cfg_wdata_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      out_req_q.raw_heading    <= HEADING_W'(raw_heading);
      out_req_q.smooth_heading <= HEADING_W'(smooth_heading);
      out_req_q.sector         <= sector;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_req_o   = out_req_q;

  a_accept_blocks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (in_stall_o && state_q == ST_ROTATE))
    else $error("sample taken without starting the CORDIC pass");

  a_emit_delivers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && !(out_valid_q && out_stall_i)) |=> (out_valid_o && state_q == ST_IDLE))
    else $error("finished result not loaded into the result register");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |-> !out_load)
    else $error("stalled result overwritten");

  a_heading_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ((HD_W > HEADING_W) ||
      (int'(out_req_o.raw_heading) < FULL_TURN_I &&
       int'(out_req_o.smooth_heading) < FULL_TURN_I)))
    else $error("heading outside one turn");

endmodule

FILE: tb/sv/tb_compass_heading_smoother.sv
// Self-checking testbench for compass_heading_smoother: directed and random X/Y sample requests
// under bursty input and a patterned output stall, checked against an in-bench heading model.
// Depends on chs_pkg and the compass_heading_smoother RTL.
module tb_compass_heading_smoother;
  import chs_pkg::*;

  localparam longint FULL_ACC      = longint'(FULL_ACC_I);
  localparam longint FULL_TURN     = longint'(FULL_TURN_I);
  localparam longint HALF_TURN     = longint'(HALF_TURN_I);
  localparam longint SECTOR_OFFSET = longint'(SECTOR_OFFSET_I);
  localparam longint SECTOR_SPAN   = longint'(45) << ANGLE_FRACTION_BITS;
  localparam int     CYCLE_LIMIT   = 500000;
  localparam int     DRAIN_CYCLES  = 60;
  localparam int     PHASE_ITEMS   = 75;

  logic                clk_i;
  logic                rst_ni;
  logic                cfg_we_i;
  logic [FACTOR_W-1:0] cfg_wdata_i;
  logic                in_valid_i;
  logic                in_stall_o;
  chs_in_t             in_req_i;
  logic                out_valid_o;
  logic                out_stall_i;
  chs_out_t            out_req_o;

  chs_in_t             pending_samples[$];
  chs_out_t            expected_results[$];
  longint              smooth_state;
  logic [FACTOR_W-1:0] factor_model;
  int                  mismatch_count;
  int                  cycle_count;
  logic                in_fire;
  int                  burst_left;
  int                  gap_left;
  int                  stall_mode;
  int                  stall_phase;

  compass_heading_smoother u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_req_o   (out_req_o)
  );

  always #5 clk_i = ~clk_i;

  function automatic chs_out_t predict_heading(chs_in_t smp);
    longint   x;
    longint   y;
    longint   z;
    longint   xs;
    longint   ys;
    longint   raw;
    longint   diff;
    longint   stp;
    longint   s;
    chs_out_t r;
    x   = longint'($signed(smp.field_x));
    y   = longint'($signed(smp.field_y));
    raw = 0;
    if (x != 0 || y != 0) begin
      x = x * 256;
      y = y * 256;
      z = 0;
      if (x < 0) begin
        x = -x;
        y = -y;
        z = longint'(180) << ACC_FRAC;
      end
      for (int i = 0; i < ITER_CNT; i++) begin
        xs = x >>> i;
        ys = y >>> i;
        if (y >= 0) begin
          x = x + ys;
          y = y - xs;
          z = z + longint'(ATAN_TABLE[i]);
        end else begin
          x = x - ys;
          y = y + xs;
          z = z - longint'(ATAN_TABLE[i]);
        end
      end
      if (z < 0) z = z + FULL_ACC;
      if (z >= FULL_ACC) z = z - FULL_ACC;
      raw = (z + (longint'(1) << (RND_SH - 1))) >>> RND_SH;
      if (raw >= FULL_TURN) raw = raw - FULL_TURN;
    end
    diff = raw - smooth_state;
    if (diff > HALF_TURN) diff = diff - FULL_TURN;
    else if (diff < -HALF_TURN) diff = diff + FULL_TURN;
    stp = (diff * longint'(factor_model) + 32768) >>> 16;
    s = smooth_state + stp;
    if (s < 0) s = s + FULL_TURN;
    else if (s >= FULL_TURN) s = s - FULL_TURN;
    smooth_state     = s;
    r.raw_heading    = HEADING_W'(raw);
    r.smooth_heading = HEADING_W'(s);
    r.sector         = SECTOR_W'((s + SECTOR_OFFSET) / SECTOR_SPAN);
    return r;
  endfunction

  function automatic chs_in_t make_sample();
    chs_in_t     smp;
    int unsigned mode;
    logic [15:0] v;
    mode = $urandom_range(0, 9);
    v    = 16'($urandom);
    case (mode)
      0, 1, 2, 3: begin
        smp.field_x = v;
        smp.field_y = 16'($urandom);
      end
      4: begin
        smp.field_x = 16'(int'($urandom_range(0, 8)) - 4);
        smp.field_y = 16'(int'($urandom_range(0, 8)) - 4);
      end
      5: begin
        smp.field_x = $urandom_range(0, 1) ? v : 16'd0;
        smp.field_y = (smp.field_x == 16'd0) ? v : 16'd0;
      end
      6: begin
        smp.field_x = v;
        smp.field_y = $urandom_range(0, 1) ? v : -v;
      end
      7, 8: begin
        smp.field_x = 16'($urandom_range(8000, 32767));
        smp.field_y = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
      default: begin
        smp.field_x = 16'(-int'($urandom_range(8000, 32768)));
        smp.field_y = 16'(int'($urandom_range(0, 4000)) - 2000);
      end
    endcase
    return smp;
  endfunction

  function automatic chs_in_t pack_sample(int fx, int fy);
    chs_in_t smp;
    smp.field_x = 16'(fx);
    smp.field_y = 16'(fy);
    return smp;
  endfunction

  task automatic wait_drained();
    while (pending_samples.size() != 0 || in_valid_i || expected_results.size() != 0)
      @(posedge clk_i);
  endtask

  task automatic write_factor(input logic [FACTOR_W-1:0] value);
    @(negedge clk_i);
    cfg_we_i     <= 1'b1;
    cfg_wdata_i  <= value;
    factor_model = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Driver: bursts of requests separated by random gaps
  always @(negedge clk_i) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_fire) begin
      in_valid_i <= 1'b1;
    end else if (gap_left > 0) begin
      in_valid_i <= 1'b0;
      gap_left   = gap_left - 1;
    end else if (pending_samples.size() != 0) begin
      in_req_i   <= pending_samples.pop_front();
      in_valid_i <= 1'b1;
      burst_left = burst_left - 1;
      if (burst_left <= 0) begin
        if ($urandom_range(0, 7) == 0) begin
          burst_left = $urandom_range(30, 60);
          gap_left   = 0;
        end else begin
          burst_left = $urandom_range(1, 12);
          gap_left   = $urandom_range(0, 30);
        end
      end
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Receiver stall pattern
  always @(negedge clk_i) begin
    if (stall_phase == 0) begin
      stall_mode  = $urandom_range(0, 3);
      stall_phase = $urandom_range(16, 96);
    end else begin
      stall_phase = stall_phase - 1;
    end
    case (stall_mode)
      0:       out_stall_i <= 1'b0;
      1:       out_stall_i <= ($urandom_range(0, 3) == 0);
      2:       out_stall_i <= ($urandom_range(0, 3) != 0);
      default: out_stall_i <= ((cycle_count % 37) < 20);
    endcase
  end

  always @(posedge clk_i) begin : monitor_b
    chs_out_t exp_r;
    in_fire <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni) begin
      if (in_valid_i && !in_stall_o)
        expected_results.push_back(predict_heading(in_req_i));
      if (out_valid_o && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          mismatch_count = mismatch_count + 1;
          if (mismatch_count <= 10)
            $display("unexpected result: raw %0d smooth %0d sector %0d",
                     out_req_o.raw_heading, out_req_o.smooth_heading, out_req_o.sector);
        end else begin
          exp_r = expected_results.pop_front();
          if (out_req_o.raw_heading !== exp_r.raw_heading ||
              out_req_o.smooth_heading !== exp_r.smooth_heading ||
              out_req_o.sector !== exp_r.sector) begin
            mismatch_count = mismatch_count + 1;
            if (mismatch_count <= 10)
              $display("mismatch: exp raw %0d smooth %0d sector %0d, got raw %0d smooth %0d sector %0d",
                       exp_r.raw_heading, exp_r.smooth_heading, exp_r.sector,
                       out_req_o.raw_heading, out_req_o.smooth_heading, out_req_o.sector);
          end
        end
      end
    end
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb_compass_heading_smoother: errors");
      $finish;
    end
  end

  initial begin
    logic [FACTOR_W-1:0] phase_factor;
    clk_i          = 1'b0;
    rst_ni         = 1'b0;
    cfg_we_i       = 1'b0;
    cfg_wdata_i    = '0;
    in_valid_i     = 1'b0;
    in_req_i       = '0;
    out_stall_i    = 1'b0;
    in_fire        = 1'b0;
    smooth_state   = 0;
    factor_model   = FACTOR_RESET;
    mismatch_count = 0;
    cycle_count    = 0;
    burst_left     = 4;
    gap_left       = 0;
    stall_mode     = 0;
    stall_phase    = 20;
    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    pending_samples.push_back(pack_sample(0, 0));
    pending_samples.push_back(pack_sample(32767, 0));
    pending_samples.push_back(pack_sample(-32768, 0));
    pending_samples.push_back(pack_sample(0, 32767));
    pending_samples.push_back(pack_sample(0, -32768));
    pending_samples.push_back(pack_sample(32767, 32767));
    pending_samples.push_back(pack_sample(-32768, -32768));
    pending_samples.push_back(pack_sample(32767, -32768));
    pending_samples.push_back(pack_sample(-32768, 32767));
    pending_samples.push_back(pack_sample(1, 0));
    pending_samples.push_back(pack_sample(0, 1));
    pending_samples.push_back(pack_sample(-1, 0));
    pending_samples.push_back(pack_sample(0, -1));
    pending_samples.push_back(pack_sample(-1, -1));
    pending_samples.push_back(pack_sample(1, -1));
    pending_samples.push_back(pack_sample(-1, 1));
    pending_samples.push_back(pack_sample(32767, -1));
    pending_samples.push_back(pack_sample(32767, 1));
    pending_samples.push_back(pack_sample(32767, -100));
    pending_samples.push_back(pack_sample(32767, 100));
    pending_samples.push_back(pack_sample(-32768, -1));
    pending_samples.push_back(pack_sample(-32768, 1));
    pending_samples.push_back(pack_sample(0, 0));
    wait_drained();

    for (int p = 0; p < 8; p++) begin
      case (p)
        0:       phase_factor = 16'hFFFF;
        1:       phase_factor = 16'h0000;
        2:       phase_factor = 16'h0001;
        3:       phase_factor = 16'h8000;
        4:       phase_factor = FACTOR_RESET;
        default: phase_factor = 16'($urandom);
      endcase
      write_factor(phase_factor);
      repeat (PHASE_ITEMS) pending_samples.push_back(make_sample());
      wait_drained();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && expected_results.size() == 0) begin
      $display("tb_compass_heading_smoother: clean");
    end else begin
      $display("tb_compass_heading_smoother: errors");
    end
    $finish;
  end

endmodule
